@@ rtl/cmau_pkg.sv @@
`default_nettype none

package cmau_pkg;

    // Store geometry: eight byte-wide banks, one row holds eight consecutive bytes
    localparam int MEM_BYTES = 65536;
    localparam int BANKS     = 8;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROW_DEPTH = MEM_BYTES / BANKS;
    localparam int ROW_W     = ADDR_W - $clog2(BANKS);
    localparam int LIM_W     = 17;
    localparam int LIVE_W    = (ADDR_W + 1 > LIM_W) ? ADDR_W + 1 : LIM_W;

    // Configuration register indexes
    localparam logic [1:0] REG_MEMORY_LIMIT   = 2'd0;
    localparam logic [1:0] REG_READONLY_LIMIT = 2'd1;
    localparam logic [1:0] REG_STACK_LIMIT    = 2'd2;

    localparam logic [LIM_W-1:0] MEMORY_LIMIT_RESET = LIM_W'(65536);

    // Actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_PUSH  = 2'd2;
    localparam logic [1:0] ACT_POP   = 2'd3;

    // Size codes
    localparam logic [1:0] SIZE_1 = 2'd0;
    localparam logic [1:0] SIZE_2 = 2'd1;
    localparam logic [1:0] SIZE_4 = 2'd2;
    localparam logic [1:0] SIZE_8 = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BOUNDS    = 2'd1;
    localparam logic [1:0] ST_VIOLATION = 2'd2;
    localparam logic [1:0] ST_STACK     = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] address;
        logic [1:0]  size_code;
        logic [63:0] write_data;
        logic [63:0] stack_pointer;
    } cmau_in_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [1:0]  status;
        logic [63:0] stack_pointer_out;
    } cmau_out_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic              is_write;
        logic              is_read;
        logic [ADDR_W-1:0] ea;
        logic [1:0]        size_code;
        logic [63:0]       write_data;
        logic [1:0]        status;
        logic [63:0]       stack_pointer_out;
    } cmau_cmd_t;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] addr;
        logic [7:0]       wdata;
    } cmau_bank_req_t;

endpackage

`default_nettype wire

@@ rtl/cmau_ram.sv @@
`default_nettype none

module cmau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

endmodule

`default_nettype wire

@@ rtl/cmau_front.sv @@
`default_nettype none

module cmau_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire cmau_pkg::cmau_in_t          access,
    input  wire logic                        cfg_write,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [cmau_pkg::LIM_W-1:0]  cfg_data,
    output logic                             cmd_valid,
    output cmau_pkg::cmau_cmd_t              cmd,
    input  wire logic                        cmd_take
);

    localparam int CMD_DEPTH = 2;
    localparam int PTR_W     = $clog2(CMD_DEPTH);
    localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

    logic [cmau_pkg::LIM_W-1:0] mem_lim_reg;
    logic [cmau_pkg::LIM_W-1:0] ro_lim_reg;
    logic [cmau_pkg::LIM_W-1:0] stk_lim_reg;

    cmau_pkg::cmau_cmd_t q_reg [CMD_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [cmau_pkg::LIVE_W-1:0] live;
    logic [63:0]                 size64, sp_dec, sp_inc, ea;
    logic                        bounds_ok, ro_hit, stk_hit, accept;
    cmau_pkg::cmau_cmd_t         cls;

    // Usable bytes: limit clamped to the store size
    always_comb
    begin
        if (cmau_pkg::LIVE_W'(mem_lim_reg) > cmau_pkg::LIVE_W'(cmau_pkg::MEM_BYTES))
            live = cmau_pkg::LIVE_W'(cmau_pkg::MEM_BYTES);
        else
            live = cmau_pkg::LIVE_W'(mem_lim_reg);
    end

    // Classification
    always_comb
    begin
        size64 = 64'd1 << access.size_code;
        sp_dec = access.stack_pointer - size64;
        sp_inc = access.stack_pointer + size64;

        unique case (access.action)
            cmau_pkg::ACT_PUSH: ea = sp_dec;
            cmau_pkg::ACT_POP:  ea = access.stack_pointer;
            default:            ea = access.address;
        endcase

        // ea < live rules out overflow of ea + size
        bounds_ok = (ea < 64'(live)) && ((ea + size64) <= 64'(live));
        ro_hit    = ea < 64'(ro_lim_reg);
        stk_hit   = ea < 64'(stk_lim_reg);

        cls.is_write          = 1'b0;
        cls.is_read           = 1'b0;
        cls.ea                = ea[cmau_pkg::ADDR_W-1:0];
        cls.size_code         = access.size_code;
        cls.write_data        = access.write_data;
        cls.status            = cmau_pkg::ST_OK;
        cls.stack_pointer_out = access.stack_pointer;

        unique case (access.action)
            cmau_pkg::ACT_READ:
            begin
                cls.status  = bounds_ok ? cmau_pkg::ST_OK : cmau_pkg::ST_BOUNDS;
                cls.is_read = bounds_ok;
            end
            cmau_pkg::ACT_WRITE:
            begin
                if (!bounds_ok)
                    cls.status = cmau_pkg::ST_BOUNDS;
                else if (ro_hit)
                    cls.status = cmau_pkg::ST_VIOLATION;
                cls.is_write = bounds_ok && !ro_hit;
            end
            cmau_pkg::ACT_PUSH:
            begin
                if (stk_hit)
                    cls.status = cmau_pkg::ST_STACK;
                else if (!bounds_ok)
                    cls.status = cmau_pkg::ST_BOUNDS;
                else if (ro_hit)
                    cls.status = cmau_pkg::ST_VIOLATION;
                cls.is_write          = !stk_hit && bounds_ok && !ro_hit;
                cls.stack_pointer_out = sp_dec;
            end
            cmau_pkg::ACT_POP:
            begin
                if (stk_hit)
                    cls.status = cmau_pkg::ST_STACK;
                else if (!bounds_ok)
                    cls.status = cmau_pkg::ST_BOUNDS;
                cls.is_read = !stk_hit && bounds_ok;
                if (!stk_hit && bounds_ok)
                    cls.stack_pointer_out = sp_inc;
            end
            default:
            begin
                cls.status = cmau_pkg::ST_OK;
            end
        endcase
    end

    // Command queue
    assign full      = (cnt_reg == CNT_W'(CMD_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (accept)
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        if (cmd_take)
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        if (accept && !cmd_take)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (!accept && cmd_take)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            mem_lim_reg <= cmau_pkg::MEMORY_LIMIT_RESET;
            ro_lim_reg  <= '0;
            stk_lim_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    cmau_pkg::REG_MEMORY_LIMIT:   mem_lim_reg <= cfg_data;
                    cmau_pkg::REG_READONLY_LIMIT: ro_lim_reg  <= cfg_data;
                    cmau_pkg::REG_STACK_LIMIT:    stk_lim_reg <= cfg_data;
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // Only classified commands that passed every check may touch memory
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cls.is_write || cls.is_read)) |-> (cls.status == cmau_pkg::ST_OK))
        else $error("memory access issued for a failed item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !cmd_take) |=> $stable(cnt_reg))
        else $error("command queue changed while full and stalled");

endmodule

`default_nettype wire

@@ rtl/cmau_back.sv @@
`default_nettype none

module cmau_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    input  wire cmau_pkg::cmau_cmd_t        cmd,
    output logic                            cmd_take,
    output cmau_pkg::cmau_bank_req_t        bank_req   [cmau_pkg::BANKS],
    input  wire logic [7:0]                 bank_rdata [cmau_pkg::BANKS],
    input  wire logic                       pop,
    output logic                            empty,
    output cmau_pkg::cmau_out_t             reply
);

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic        is_read;
        logic [2:0]  lo;
        logic [1:0]  size_code;
        logic [1:0]  status;
        logic [63:0] stack_pointer_out;
    } s1_t;

    logic             s1_valid_reg;
    s1_t              s1_reg;

    cmau_pkg::cmau_out_t out_q_reg [OUT_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             room, out_pop;
    logic [2:0]       lo;
    logic [3:0]       nbytes;
    logic [63:0]      word, read_word, mask;
    logic [127:0]     rot;
    logic [cmau_pkg::BANKS-1:0] we_vec;
    cmau_pkg::cmau_out_t        result;

    // Issue only if the result is sure of a slot in the output queue
    assign room     = s1_valid_reg ? (cnt_reg < CNT_W'(OUT_DEPTH - 1))
                                   : (cnt_reg < CNT_W'(OUT_DEPTH));
    assign cmd_take = cmd_valid && room;
    assign lo       = cmd.ea[2:0];
    assign nbytes   = 4'd1 << cmd.size_code;

    // Byte i of the access goes to bank (lo + i) mod 8; banks below lo sit on the next row
    always_comb
    begin
        for (int b = 0; b < cmau_pkg::BANKS; b++)
        begin
            logic [2:0] idx;
            idx = 3'(b) - lo;
            bank_req[b].we    = cmd_take && cmd.is_write && ({1'b0, idx} < nbytes);
            bank_req[b].addr  = cmd.ea[cmau_pkg::ADDR_W-1:3]
                                + cmau_pkg::ROW_W'((3'(b) < lo) ? 1 : 0);
            bank_req[b].wdata = 8'(cmd.write_data >> {idx, 3'b000});
            we_vec[b]         = bank_req[b].we;
        end
    end

    // Result assembly from registered bank data
    always_comb
    begin
        for (int b = 0; b < cmau_pkg::BANKS; b++)
        begin
            word[8*b +: 8] = bank_rdata[b];
        end
        rot = {word, word} >> {s1_reg.lo, 3'b000};
        case (s1_reg.size_code)
            cmau_pkg::SIZE_1: mask = 64'h0000_0000_0000_00FF;
            cmau_pkg::SIZE_2: mask = 64'h0000_0000_0000_FFFF;
            cmau_pkg::SIZE_4: mask = 64'h0000_0000_FFFF_FFFF;
            default:          mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        read_word = s1_reg.is_read ? (rot[63:0] & mask) : 64'd0;
        result.read_data         = read_word;
        result.status            = s1_reg.status;
        result.stack_pointer_out = s1_reg.stack_pointer_out;
    end

    // Output queue
    assign empty    = (cnt_reg == '0);
    assign out_pop  = pop && !empty;
    assign reply    = out_q_reg[head_reg];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (s1_valid_reg)
            tail_next = tail_reg + PTR_W'(1);
        if (out_pop)
            head_next = head_reg + PTR_W'(1);
        if (s1_valid_reg && !out_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (!s1_valid_reg && out_pop)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd_take;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_reg.is_read           <= cmd.is_read;
            s1_reg.lo                <= lo;
            s1_reg.size_code         <= cmd.size_code;
            s1_reg.status            <= cmd.status;
            s1_reg.stack_pointer_out <= cmd.stack_pointer_out;
        end
        if (s1_valid_reg)
        begin
            out_q_reg[tail_reg] <= result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (|we_vec) |-> (cmd_take && cmd.is_write && cmd.status == cmau_pkg::ST_OK))
        else $error("bank written without a passing write command");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (cnt_reg != CNT_W'(OUT_DEPTH)))
        else $error("result arrived with the output queue full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.status != cmau_pkg::ST_OK) |-> (read_word == 64'd0))
        else $error("failed access returned data");

endmodule

`default_nettype wire

@@ rtl/checked_memory_access_unit.sv @@
// Path: an item passes the front command queue, the bank read and the output queue.
// Throughput: one item per cycle while results are popped; one access to each
// of eight byte banks per cycle, so any 1/2/4/8-byte access, aligned or not, fits.
// Reset: rst_n asynchronous, active low; empties both queues, memory_limit to 65536,
// readonly_limit and stack_limit to 0. Memory contents are not cleared.
`default_nettype none

module checked_memory_access_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input side
    input  wire logic                        push,
    output logic                             full,
    input  wire cmau_pkg::cmau_in_t          access,
    // configuration
    input  wire logic                        cfg_write,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [cmau_pkg::LIM_W-1:0]  cfg_data,
    // result side
    output logic                             empty,
    input  wire logic                        pop,
    output cmau_pkg::cmau_out_t              reply
);

    // Front to back: classified commands, status and new stack pointer already known
    logic                     cmd_valid;
    logic                     cmd_take;
    cmau_pkg::cmau_cmd_t      cmd;

    // Back to banks
    cmau_pkg::cmau_bank_req_t bank_req   [cmau_pkg::BANKS];
    logic [7:0]               bank_rdata [cmau_pkg::BANKS];

    // Front: holds the limit registers, checks bounds, read-only and stack limits,
    // works out the effective address and queues the command (two entries).
    cmau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .access    (access),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Back: spreads the access over the byte banks, gathers read bytes in the next
    // cycle and queues results (four entries) for the consumer.
    cmau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .bank_req   (bank_req),
        .bank_rdata (bank_rdata),
        .pop        (pop),
        .empty      (empty),
        .reply      (reply)
    );

    // Byte store: bank b holds every byte whose address is b modulo 8
    for (genvar b = 0; b < cmau_pkg::BANKS; b++)
    begin : g_bank
        cmau_ram #(
            .WIDTH (8),
            .DEPTH (cmau_pkg::ROW_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_req[b].we),
            .addr  (bank_req[b].addr),
            .wdata (bank_req[b].wdata),
            .rdata (bank_rdata[b])
        );
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_checked_memory_access_unit.sv @@
`timescale 1ns / 100ps

module tb_checked_memory_access_unit;

    localparam int CYCLE_LIMIT      = 300000;
    localparam int RANDOM_PER_PHASE = 180;
    localparam int PHASES           = 8;

    // Receiver behaviour: pop every cycle, pop at random, or follow a rotating bit pattern
    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // What one access does, worked out before any memory is touched
    typedef struct {
        logic [1:0]  status;
        logic [63:0] sp_out;
        logic [63:0] addr;      // effective address (lowered sp for push, sp for pop)
        int          nbytes;
        bit          loads;     // reads memory, only set when the access succeeds
        bit          stores;    // writes memory, only set when the access succeeds
    } access_plan_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 push = 1'b0;
    logic                 full;
    cmau_pkg::cmau_in_t   access = '0;
    logic                 cfg_write = 1'b0;
    logic [1:0]           cfg_index = cmau_pkg::REG_MEMORY_LIMIT;
    logic [cmau_pkg::LIM_W-1:0] cfg_data = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    cmau_pkg::cmau_out_t  reply;

    // Limits as the block currently holds them; only changed while it is idle
    logic [cmau_pkg::LIM_W-1:0] lim_memory   = cmau_pkg::MEMORY_LIMIT_RESET;
    logic [cmau_pkg::LIM_W-1:0] lim_readonly = '0;
    logic [cmau_pkg::LIM_W-1:0] lim_stack    = '0;

    // Byte image of the store as the predictor sees it
    logic [7:0] store_image [cmau_pkg::MEM_BYTES];
    // Bytes that queued stimulus will have written, so no load ever sees an unwritten byte
    bit         byte_written [cmau_pkg::MEM_BYTES];

    cmau_pkg::cmau_in_t   pending_accesses [$];
    cmau_pkg::cmau_out_t  expected_results [$];

    int         error_count = 0;
    int         sent_count = 0;
    int         checked_count = 0;
    int         cycle_count = 0;
    int         status_count [4] = '{0, 0, 0, 0};
    logic [63:0] tracked_sp = 64'h200;

    // sender burst state
    int         burst_left = 1;
    int         gap_left = 0;
    logic       next_push;

    // receiver stall state
    rx_mode_t   rx_mode = RX_STEADY;
    int         rx_left = 0;
    logic [31:0] rx_pattern = '1;
    cmau_pkg::cmau_out_t want;

    checked_memory_access_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .access   (access),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .empty    (empty),
        .pop      (pop),
        .reply    (reply)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Access prediction
    // ---------------------------------------------------------------------------------

    // The whole span must sit below the live size; written so that it cannot wrap
    function automatic bit fits_in(logic [63:0] addr, logic [63:0] nbytes,
                                   logic [63:0] live);
        return (addr < live) && (nbytes <= live - addr);
    endfunction

    // Stores check bounds first, the read-only barrier second
    function automatic logic [1:0] store_status(logic [63:0] addr, logic [63:0] nbytes,
                                                logic [63:0] live);
        if (!fits_in(addr, nbytes, live))
            return cmau_pkg::ST_BOUNDS;
        if (addr < 64'(lim_readonly))
            return cmau_pkg::ST_VIOLATION;
        return cmau_pkg::ST_OK;
    endfunction

    function automatic access_plan_t plan_access(cmau_pkg::cmau_in_t it);
        access_plan_t p;
        logic [63:0] nbytes;
        logic [63:0] live;
        nbytes = 64'd1 << it.size_code;
        // a memory limit above the store size behaves as the store size
        live = (lim_memory > cmau_pkg::MEM_BYTES) ? 64'(cmau_pkg::MEM_BYTES)
                                                  : 64'(lim_memory);
        p.status = cmau_pkg::ST_OK;
        p.nbytes = int'(nbytes);
        p.sp_out = it.stack_pointer;
        p.addr   = it.address;
        p.loads  = 1'b0;
        p.stores = 1'b0;
        case (it.action)
            cmau_pkg::ACT_READ:
            begin
                p.status = fits_in(p.addr, nbytes, live) ? cmau_pkg::ST_OK
                                                         : cmau_pkg::ST_BOUNDS;
                p.loads  = 1'b1;
            end
            cmau_pkg::ACT_WRITE:
            begin
                p.status = store_status(p.addr, nbytes, live);
                p.stores = 1'b1;
            end
            cmau_pkg::ACT_PUSH:
            begin
                // lowered pointer is reported whatever happens next
                p.sp_out = it.stack_pointer - nbytes;
                p.addr   = p.sp_out;
                if (p.sp_out < 64'(lim_stack))
                    p.status = cmau_pkg::ST_STACK;
                else
                begin
                    p.status = store_status(p.addr, nbytes, live);
                    p.stores = 1'b1;
                end
            end
            cmau_pkg::ACT_POP:
            begin
                p.addr = it.stack_pointer;
                if (p.addr < 64'(lim_stack))
                    p.status = cmau_pkg::ST_STACK;
                else
                begin
                    p.status = fits_in(p.addr, nbytes, live) ? cmau_pkg::ST_OK
                                                             : cmau_pkg::ST_BOUNDS;
                    p.loads  = 1'b1;
                    // pointer only moves up on a good pop
                    if (p.status == cmau_pkg::ST_OK)
                        p.sp_out = it.stack_pointer + nbytes;
                end
            end
        endcase
        if (p.status != cmau_pkg::ST_OK)
        begin
            p.loads  = 1'b0;
            p.stores = 1'b0;
        end
        return p;
    endfunction

    // Applies one accepted access to the byte image and records the result it must give
    function automatic void apply_access(cmau_pkg::cmau_in_t it);
        access_plan_t p;
        cmau_pkg::cmau_out_t res;
        p = plan_access(it);
        res.read_data         = '0;
        res.status            = p.status;
        res.stack_pointer_out = p.sp_out;
        for (int i = 0; i < p.nbytes; i++)
        begin
            // little-endian: byte i of the span is bits 8i upwards
            if (p.loads)
                res.read_data[8*i +: 8] = store_image[int'(p.addr) + i];
            if (p.stores)
                store_image[int'(p.addr) + i] = it.write_data[8*i +: 8];
        end
        expected_results = {expected_results, res};
        status_count[p.status]++;
    endfunction

    // ---------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------

    // Queues one access. A successful load that would touch a byte never written is
    // turned into a store over the same span, which also fills the store as we go.
    function automatic access_plan_t queue_access(cmau_pkg::cmau_in_t it);
        access_plan_t p;
        bit fresh;
        p = plan_access(it);
        fresh = 1'b0;
        if (p.loads)
            for (int i = 0; i < p.nbytes; i++)
                if (!byte_written[int'(p.addr) + i])
                    fresh = 1'b1;
        if (fresh)
        begin
            it.action  = cmau_pkg::ACT_WRITE;
            it.address = p.addr;
            p = plan_access(it);
        end
        if (p.stores)
            for (int i = 0; i < p.nbytes; i++)
                byte_written[int'(p.addr) + i] = 1'b1;
        pending_accesses = {pending_accesses, it};
        return p;
    endfunction

    function automatic void queue_op(logic [1:0] act, logic [63:0] addr, logic [1:0] sz,
                                     logic [63:0] data, logic [63:0] sp);
        cmau_pkg::cmau_in_t it;
        it.action        = act;
        it.address       = addr;
        it.size_code     = sz;
        it.write_data    = data;
        it.stack_pointer = sp;
        void'(queue_access(it));
    endfunction

    // A value a little either side of base, never below zero
    function automatic logic [63:0] around(logic [63:0] base, int below, int above);
        longint v;
        v = longint'(base) - below + longint'($urandom_range(0, below + above));
        return (v < 0) ? 64'd0 : 64'(v);
    endfunction

    // Random accesses, aimed mostly at the filled regions and the edges of the limits.
    // Half of them walk one stack pointer with push/pop so pushed data is popped back.
    task automatic queue_random_accesses(int count);
        cmau_pkg::cmau_in_t it;
        access_plan_t p;
        logic [63:0] live;
        int pick;
        bit on_stack;
        live = (lim_memory > cmau_pkg::MEM_BYTES) ? 64'(cmau_pkg::MEM_BYTES)
                                                  : 64'(lim_memory);
        repeat (count)
        begin
            it.action     = 2'($urandom_range(0, 3));
            it.size_code  = 2'($urandom_range(0, 3));
            it.write_data = {$urandom, $urandom};

            pick = $urandom_range(0, 99);
            if (pick < 40)
                it.address = 64'($urandom_range(0, 'h3FF));
            else if (pick < 55)
                it.address = around(live, 16, 8);
            else if (pick < 65)
                it.address = around(64'(lim_readonly), 16, 16);
            else if (pick < 75)
                it.address = 64'($urandom_range(65512, 65543));
            else if (pick < 90)
                it.address = {$urandom, $urandom};
            else
                it.address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));

            on_stack = ($urandom_range(0, 1) == 1);
            if (on_stack)
            begin
                it.action        = ($urandom_range(0, 1) == 1) ? cmau_pkg::ACT_PUSH
                                                               : cmau_pkg::ACT_POP;
                it.stack_pointer = tracked_sp;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    it.stack_pointer = around(64'(lim_stack), 24, 24);
                else if (pick < 65)
                    it.stack_pointer = 64'($urandom_range(8, 'h400));
                else if (pick < 75)
                    it.stack_pointer = 64'($urandom_range(0, 8));   // push wraps past zero
                else if (pick < 85)
                    it.stack_pointer = {$urandom, $urandom};
                else
                    it.stack_pointer = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
            end

            p = queue_access(it);
            if (on_stack)
            begin
                tracked_sp = p.sp_out;
                // start a fresh walk after a fault, and now and then anyway
                if (p.status != cmau_pkg::ST_OK || $urandom_range(0, 31) == 0)
                    tracked_sp = around(64'(lim_stack), 8, 120);
            end
        end
    endtask

    // Writes all three limits; the block is idle whenever this is called
    task automatic write_limits(logic [cmau_pkg::LIM_W-1:0] mem_lim,
                                logic [cmau_pkg::LIM_W-1:0] ro_lim,
                                logic [cmau_pkg::LIM_W-1:0] stk_lim);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= cmau_pkg::REG_MEMORY_LIMIT;
        cfg_data  <= mem_lim;
        @(posedge clk);
        cfg_index <= cmau_pkg::REG_READONLY_LIMIT;
        cfg_data  <= ro_lim;
        @(posedge clk);
        cfg_index <= cmau_pkg::REG_STACK_LIMIT;
        cfg_data  <= stk_lim;
        @(posedge clk);
        cfg_write <= 1'b0;
        lim_memory   = mem_lim;
        lim_readonly = ro_lim;
        lim_stack    = stk_lim;
    endtask

    // Waits until every queued access has been transferred and answered, then lets the
    // pipeline settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_accesses.size() != 0 || push || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Reset limits: whole store, no read-only region, no stack barrier.
        // Directed accesses: every size, unaligned spans, the top of the store,
        // addresses that wrap, and push/pop round trips.
        queue_op(cmau_pkg::ACT_WRITE, 64'h0, cmau_pkg::SIZE_8, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0001);
        queue_op(cmau_pkg::ACT_WRITE, 64'h8, cmau_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF,
                 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'h0, cmau_pkg::SIZE_1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_op(cmau_pkg::ACT_READ, 64'h1, cmau_pkg::SIZE_2, 64'h0, 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'h2, cmau_pkg::SIZE_4, 64'h0, 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'h5, cmau_pkg::SIZE_8, 64'h0, 64'h0);
        // truncated to two bytes
        queue_op(cmau_pkg::ACT_WRITE, 64'h3, cmau_pkg::SIZE_2, 64'hA5A5_A5A5_A5A5_BEEF,
                 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'h0, cmau_pkg::SIZE_8, 64'h0, 64'h0);
        queue_op(cmau_pkg::ACT_WRITE, 64'd65528, cmau_pkg::SIZE_8, 64'hFEDC_BA98_7654_3210,
                 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'd65535, cmau_pkg::SIZE_1, 64'h0, 64'h0);
        // straddles the end
        queue_op(cmau_pkg::ACT_READ, 64'd65535, cmau_pkg::SIZE_2, 64'h0, 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'd65536, cmau_pkg::SIZE_1, 64'h0, 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'hFFFF_FFFF_FFFF_FFFF, cmau_pkg::SIZE_8, 64'h0, 64'h0);
        queue_op(cmau_pkg::ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, cmau_pkg::SIZE_8, 64'h1,
                 64'h0);
        queue_op(cmau_pkg::ACT_PUSH, 64'h0, cmau_pkg::SIZE_8, 64'h5555_AAAA_3333_CCCC,
                 64'h100);
        queue_op(cmau_pkg::ACT_POP, 64'h0, cmau_pkg::SIZE_8, 64'h0, 64'hF8);
        // pointer wraps below zero
        queue_op(cmau_pkg::ACT_PUSH, 64'h0, cmau_pkg::SIZE_1, 64'h77, 64'h0);
        queue_op(cmau_pkg::ACT_POP, 64'h0, cmau_pkg::SIZE_4, 64'h0, 64'hFFFF_FFFF_FFFF_FFFC);
        queue_op(cmau_pkg::ACT_PUSH, 64'h0, cmau_pkg::SIZE_2, 64'hC3C3, 64'd65536);
        queue_op(cmau_pkg::ACT_POP, 64'h0, cmau_pkg::SIZE_2, 64'h0, 64'd65534);
        queue_op(cmau_pkg::ACT_POP, 64'h0, cmau_pkg::SIZE_8, 64'h0, 64'd65532);
        queue_op(cmau_pkg::ACT_WRITE, 64'h7, cmau_pkg::SIZE_4, 64'h0, 64'h0);
        queue_op(cmau_pkg::ACT_READ, 64'h4, cmau_pkg::SIZE_8, 64'h0, 64'h0);

        // fill the working regions while nothing is read-only
        for (int a = 0; a < 'h400; a += 8)
            queue_op(cmau_pkg::ACT_WRITE, 64'(a), cmau_pkg::SIZE_8, {$urandom, $urandom},
                     64'h0);
        for (int a = 65280; a < 65536; a += 8)
            queue_op(cmau_pkg::ACT_WRITE, 64'(a), cmau_pkg::SIZE_8, {$urandom, $urandom},
                     64'h0);

        queue_random_accesses(RANDOM_PER_PHASE);
        wait_idle();

        for (int ph = 1; ph < PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    write_limits(17'd65536, 17'h100, 17'h200);
                    queue_op(cmau_pkg::ACT_WRITE, 64'hFF, cmau_pkg::SIZE_1, 64'h11, 64'h0);
                    queue_op(cmau_pkg::ACT_WRITE, 64'hFE, cmau_pkg::SIZE_4, 64'h2222_2222,
                             64'h0);
                    queue_op(cmau_pkg::ACT_WRITE, 64'h100, cmau_pkg::SIZE_1, 64'h33, 64'h0);
                    // lands below the barrier
                    queue_op(cmau_pkg::ACT_PUSH, 64'h0, cmau_pkg::SIZE_8, 64'h44, 64'h207);
                    queue_op(cmau_pkg::ACT_POP, 64'h0, cmau_pkg::SIZE_1, 64'h0, 64'h1FF);
                    queue_op(cmau_pkg::ACT_POP, 64'h0, cmau_pkg::SIZE_8, 64'h0, 64'h200);
                end
                2: write_limits(17'h300, 17'h40, 17'h180);
                3:
                begin
                    // nothing is in bounds
                    write_limits(17'd0, 17'd0, 17'd0);
                    queue_op(cmau_pkg::ACT_READ, 64'h0, cmau_pkg::SIZE_1, 64'h0, 64'h0);
                end
                4:
                begin
                    // everything read-only: bounds must still win over the violation
                    write_limits(17'd65535, 17'd65536, 17'd65536);
                    queue_op(cmau_pkg::ACT_WRITE, 64'd65535, cmau_pkg::SIZE_2, 64'h5A5A,
                             64'h0);
                    queue_op(cmau_pkg::ACT_WRITE, 64'd65534, cmau_pkg::SIZE_1, 64'h5A, 64'h0);
                    queue_op(cmau_pkg::ACT_READ, 64'd65535, cmau_pkg::SIZE_1, 64'h0, 64'h0);
                    queue_op(cmau_pkg::ACT_READ, 64'd65534, cmau_pkg::SIZE_1, 64'h0, 64'h0);
                end
                5: write_limits(17'h1000, 17'h3FF, 17'h3F0);
                6: write_limits(cmau_pkg::LIM_W'($urandom_range('h200, 65536)),
                                cmau_pkg::LIM_W'($urandom_range(0, 'h400)),
                                cmau_pkg::LIM_W'($urandom_range(0, 'h400)));
                default: write_limits(17'd65536, 17'd0, 17'd0);
            endcase
            queue_random_accesses(RANDOM_PER_PHASE);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("Ran %0d transfers under %0d limit settings; %0d results checked.",
                 sent_count, PHASES, checked_count);
        $display("Status mix: %0d ok, %0d out of bounds, %0d violation, %0d stack overflow.",
                 status_count[cmau_pkg::ST_OK], status_count[cmau_pkg::ST_BOUNDS],
                 status_count[cmau_pkg::ST_VIOLATION], status_count[cmau_pkg::ST_STACK]);
        if (error_count == 0 && expected_results.size() == 0)
            $display("** checked_memory_access_unit: PASSED **");
        else
            $display("** checked_memory_access_unit: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, some bursts back to back.
    // A transfer is predicted at the edge that accepts it.
    // ---------------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            access     <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            next_push = push;
            if (push && !full)
            begin
                apply_access(access);
                sent_count++;
                next_push = 1'b0;
            end
            // push held high with full set: keep the same item on the port
            if (!next_push)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_accesses.size() != 0)
                begin
                    access <= pending_accesses.pop_front();
                    next_push = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
            push <= next_push;
        end
    end

    // ---------------------------------------------------------------------------------
    // Receiver: checks each transfer against the oldest expected result, field by field,
    // and stalls in stretches of its own
    // ---------------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            rx_mode    = RX_STEADY;
            rx_left    = 0;
            rx_pattern = '1;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %h", $time, reply);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (reply.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h, got %h",
                                 $time, want.read_data, reply.read_data);
                        error_count++;
                    end
                    if (reply.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, reply.status);
                        error_count++;
                    end
                    if (reply.stack_pointer_out !== want.stack_pointer_out)
                    begin
                        $display("%0t: stack_pointer_out expected %h, got %h",
                                 $time, want.stack_pointer_out, reply.stack_pointer_out);
                        error_count++;
                    end
                end
            end

            if (rx_left == 0)
            begin
                rx_mode    = rx_mode_t'($urandom_range(0, 2));
                rx_left    = $urandom_range(16, 120);
                rx_pattern = $urandom;
            end
            else
                rx_left--;
            rx_pattern = {rx_pattern[30:0], rx_pattern[31]};
            case (rx_mode)
                RX_STEADY: pop <= 1'b1;
                RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
                default:   pop <= rx_pattern[0];
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("** checked_memory_access_unit: FAILED **");
            $finish;
        end
    end

endmodule

@@ sim.f @@
rtl/cmau_pkg.sv
rtl/cmau_ram.sv
rtl/cmau_front.sv
rtl/cmau_back.sv
rtl/checked_memory_access_unit.sv
tb/sv/tb_checked_memory_access_unit.sv
